/* hw/rtl/spl_pkg.sv */
// Shared constants and types for the sorted priority list.
// No dependencies; imported by spl_cell and sorted_priority_list_core.
package spl_pkg;

    localparam int CAPACITY     = 16;
    localparam int KEY_WIDTH    = 32;
    localparam int HANDLE_WIDTH = 4;
    localparam int IN_KEY_WIDTH = 32;
    localparam int OUT_KEY_WIDTH = 32;
    localparam int CMD_WIDTH    = 2;
    localparam int CNT_WIDTH    = $clog2(CAPACITY + 1);
    localparam int S_DATA_WIDTH = 40;
    localparam int M_DATA_WIDTH = 40;

    localparam logic [CMD_WIDTH-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_WIDTH-1:0] CMD_POP    = 2'd1;
    localparam logic [CMD_WIDTH-1:0] CMD_REMOVE = 2'd2;

    typedef logic [HANDLE_WIDTH-1:0] t_handle;
    typedef logic [KEY_WIDTH-1:0]    t_key;

    typedef struct packed {
        logic ins;
        logic pop;
        logic rem;
    } t_cell_ctl;

endpackage

/* hw/rtl/sorted_priority_list_core.sv */
// Sorted priority list: a row of spl_cell positions kept in ascending key order.
// Depends on spl_pkg and spl_cell.
//
// Usage:
//   Slave channel carries one command item: cmd (0 insert, 1 pop front,
//   2 remove by handle), node_handle and key_value. Every accepted item
//   yields exactly one result item on the master channel: out_handle,
//   out_valid and out_key.
//   The result is registered and presented in the cycle after the item is accepted.
//   Throughput: one item per cycle while the receiver keeps up; all cells compare
//   and shift in parallel in the accept cycle, so the cell row sets the rate.
//   The single output register frees in the cycle it is taken, so
//   s_axis_tready stays high while the receiver keeps up. When the receiver
//   stalls, the result holds and s_axis_tready drops until it is taken.
//   Reset (i_rst_n low, synchronous) empties the list and drops the pending
//   result; stored positions are not cleared, only the entry count.
//   Insert ignores a present handle or a full list; equal keys leave in
//   first-in order.
module sorted_priority_list_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [1:0] cmd, [5:2] node_handle, [37:6] key_value, [39:38] zero
    input  logic [spl_pkg::S_DATA_WIDTH-1:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [3:0] out_handle, [4] out_valid, [36:5] out_key, [39:37] zero
    output logic [spl_pkg::M_DATA_WIDTH-1:0] m_axis_tdata
);
    import spl_pkg::*;

    logic [CMD_WIDTH-1:0]     w_cmd;
    t_handle                  w_handle;
    t_key                     w_key;
    logic                     w_acc;
    logic                     w_found;
    logic                     w_ins_ok;
    logic                     w_pop_ok;
    logic                     w_rem_ok;
    t_cell_ctl                w_ctl;

    logic [CAPACITY-1:0]      w_le;
    logic [CAPACITY-1:0]      w_left_le;
    logic [CAPACITY-1:0]      w_hit_in;
    logic [CAPACITY-1:0]      w_hit_out;
    logic [CAPACITY-1:0]      w_first;
    logic [CAPACITY-1:0]      w_occ;
    t_handle                  w_c_handle [CAPACITY];
    t_key                     w_c_key    [CAPACITY];

    t_handle                  w_sel_handle;
    t_key                     w_sel_key;

    logic [CNT_WIDTH-1:0]     r_count;
    logic [CNT_WIDTH-1:0]     n_count;
    logic                     r_out_tvalid;
    t_handle                  r_out_handle;
    logic                     r_out_valid;
    logic [OUT_KEY_WIDTH-1:0] r_out_key;

    assign w_cmd    = s_axis_tdata[CMD_WIDTH-1:0];
    assign w_handle = s_axis_tdata[CMD_WIDTH +: HANDLE_WIDTH];
    assign w_key    = KEY_WIDTH'(s_axis_tdata[CMD_WIDTH+HANDLE_WIDTH +: IN_KEY_WIDTH]);

    assign s_axis_tready = ~r_out_tvalid | m_axis_tready;
    assign w_acc         = s_axis_tvalid & s_axis_tready;

    assign w_found  = w_hit_out[CAPACITY-1];
    assign w_ins_ok = (w_cmd == CMD_INSERT) && !w_found && (r_count < CNT_WIDTH'(CAPACITY));
    assign w_pop_ok = (w_cmd == CMD_POP) && (r_count != '0);
    assign w_rem_ok = (w_cmd == CMD_REMOVE) && w_found;

    assign w_ctl.ins = w_acc & w_ins_ok;
    assign w_ctl.pop = w_acc & w_pop_ok;
    assign w_ctl.rem = w_acc & w_rem_ok;

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
            t_handle w_r_handle;
            t_key    w_r_key;
            t_handle w_l_handle;
            t_key    w_l_key;

            assign w_occ[gi] = CNT_WIDTH'(gi) < r_count;

            if (gi == 0) begin : g_head
                assign w_left_le[gi] = 1'b1;
                assign w_hit_in[gi]  = 1'b0;
                assign w_l_handle    = w_c_handle[gi];
                assign w_l_key       = w_c_key[gi];
            end else begin : g_body
                assign w_left_le[gi] = w_le[gi-1];
                assign w_hit_in[gi]  = w_hit_out[gi-1];
                assign w_l_handle    = w_c_handle[gi-1];
                assign w_l_key       = w_c_key[gi-1];
            end

            if (gi == CAPACITY - 1) begin : g_tail
                assign w_r_handle = w_c_handle[gi];
                assign w_r_key    = w_c_key[gi];
            end else begin : g_mid
                assign w_r_handle = w_c_handle[gi+1];
                assign w_r_key    = w_c_key[gi+1];
            end

            spl_cell u_cell (
                .i_clk          (i_clk),
                .i_ctl          (w_ctl),
                .i_occ          (w_occ[gi]),
                .i_handle       (w_handle),
                .i_key          (w_key),
                .i_left_le      (w_left_le[gi]),
                .i_left_handle  (w_l_handle),
                .i_left_key     (w_l_key),
                .i_right_handle (w_r_handle),
                .i_right_key    (w_r_key),
                .i_hit          (w_hit_in[gi]),
                .o_le           (w_le[gi]),
                .o_hit          (w_hit_out[gi]),
                .o_first        (w_first[gi]),
                .o_handle       (w_c_handle[gi]),
                .o_key          (w_c_key[gi])
            );
        end
    endgenerate

    always_comb begin
        w_sel_handle = '0;
        w_sel_key    = '0;
        if (w_cmd == CMD_POP) begin
            w_sel_handle = w_c_handle[0];
            w_sel_key    = w_c_key[0];
        end else begin
            for (int i = 0; i < CAPACITY; i++) begin
                if (w_first[i]) begin
                    w_sel_handle = w_sel_handle | w_c_handle[i];
                    w_sel_key    = w_sel_key | w_c_key[i];
                end
            end
        end
    end

    always_comb begin
        n_count = r_count;
        if (w_ctl.ins) begin
            n_count = r_count + CNT_WIDTH'(1);
        end else if (w_ctl.pop || w_ctl.rem) begin
            n_count = r_count - CNT_WIDTH'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count      <= '0;
            r_out_tvalid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (w_acc) begin
                r_out_tvalid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_tvalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_out_valid <= w_ins_ok | w_pop_ok | w_rem_ok;
            if (w_pop_ok || w_rem_ok) begin
                r_out_handle <= w_sel_handle;
                r_out_key    <= OUT_KEY_WIDTH'(w_sel_key);
            end else begin
                r_out_handle <= '0;
                r_out_key    <= '0;
            end
        end
    end

    assign m_axis_tvalid = r_out_tvalid;
    assign m_axis_tdata  = M_DATA_WIDTH'({r_out_key, r_out_valid, r_out_handle});

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_WIDTH'(CAPACITY))
        else $error("entry count exceeds capacity");

    a_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctl.ins |=> r_count == $past(r_count) + CNT_WIDTH'(1))
        else $error("insert did not grow the list");

    a_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && (w_cmd == CMD_POP) && (r_count == '0)) |=> (m_axis_tvalid && !r_out_valid))
        else $error("pop of empty list reported an entry");

    a_found_unique: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_first))
        else $error("handle matched at more than one position");
`endif

endmodule

/* hw/rtl/spl_cell.sv */
// One list position: holds a handle and key, shifts right on insert and left on delete.
// Depends on spl_pkg.
module spl_cell (
    input  logic               i_clk,
    input  spl_pkg::t_cell_ctl i_ctl,
    input  logic               i_occ,
    input  spl_pkg::t_handle   i_handle,
    input  spl_pkg::t_key      i_key,
    input  logic               i_left_le,
    input  spl_pkg::t_handle   i_left_handle,
    input  spl_pkg::t_key      i_left_key,
    input  spl_pkg::t_handle   i_right_handle,
    input  spl_pkg::t_key      i_right_key,
    input  logic               i_hit,
    output logic               o_le,
    output logic               o_hit,
    output logic               o_first,
    output spl_pkg::t_handle   o_handle,
    output spl_pkg::t_key      o_key
);
    import spl_pkg::*;

    t_handle r_handle;
    t_key    r_key;
    logic    w_match;

    assign w_match  = i_occ && (r_handle == i_handle);
    assign o_le     = i_occ && (r_key <= i_key);
    assign o_hit    = i_hit | w_match;
    assign o_first  = w_match & ~i_hit;
    assign o_handle = r_handle;
    assign o_key    = r_key;

    always_ff @(posedge i_clk) begin
        if (i_ctl.ins) begin
            if (!o_le) begin
                if (i_left_le) begin
                    r_handle <= i_handle;
                    r_key    <= i_key;
                end else begin
                    r_handle <= i_left_handle;
                    r_key    <= i_left_key;
                end
            end
        end else if (i_ctl.pop || (i_ctl.rem && o_hit)) begin
            r_handle <= i_right_handle;
            r_key    <= i_right_key;
        end
    end

endmodule

/* tb/tb_top.sv */
// Self-checking testbench for sorted_priority_list_core: streams insert, pop and remove
// commands, predicts each result from a local ordered list and checks every result item.
// Depends on spl_pkg and the sorted_priority_list_core RTL.
`timescale 1ns / 100ps

module tb_top;
    import spl_pkg::*;

    localparam logic [CMD_WIDTH-1:0] CMD_NOP = 2'd3;
    localparam int RANDOM_CMDS = 1925;
    localparam int STALL_LIMIT = 2000;
    localparam int HOLD_CYCLES = 300;

    typedef struct {
        logic [CMD_WIDTH-1:0] op;
        t_handle              handle;
        t_key                 key;
        bit                   drain;
    } t_cmd_item;

    typedef struct {
        logic    valid;
        t_handle handle;
        t_key    key;
    } t_list_result;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [S_DATA_WIDTH-1:0] s_axis_tdata = '0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [M_DATA_WIDTH-1:0] m_axis_tdata;

    t_cmd_item    pending_cmds[$];
    t_list_result expected_results[$];

    t_handle list_handle[CAPACITY];
    t_key    list_key[CAPACITY];
    int      list_count = 0;

    int error_count = 0;
    int cmds_accepted = 0;
    int idle_cycles = 0;
    int hold_left = 0;
    bit hold_done = 1'b0;
    bit drain_wait = 1'b0;
    bit in_fire = 1'b0;
    bit no_idle;

    assign no_idle = (cmds_accepted >= 1200) && (cmds_accepted < 1500);

    sorted_priority_list_core DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #5 i_clk = ~i_clk;

    function automatic t_list_result list_apply(logic [CMD_WIDTH-1:0] op, t_handle h, t_key k);
        t_list_result r;
        int at;
        int i;
        r.valid = 1'b0;
        r.handle = '0;
        r.key = '0;
        at = -1;
        for (i = 0; i < list_count; i++) begin
            if (list_handle[i] == h) at = i;
        end
        if (op == CMD_INSERT) begin
            if (at < 0 && list_count < CAPACITY) begin
                at = 0;
                while (at < list_count && list_key[at] <= k) at++;
                for (i = list_count; i > at; i--) begin
                    list_handle[i] = list_handle[i-1];
                    list_key[i] = list_key[i-1];
                end
                list_handle[at] = h;
                list_key[at] = k;
                list_count++;
                r.valid = 1'b1;
            end
        end else if (op == CMD_POP || op == CMD_REMOVE) begin
            if (op == CMD_POP) at = (list_count > 0) ? 0 : -1;
            if (at >= 0) begin
                r.valid = 1'b1;
                r.handle = list_handle[at];
                r.key = list_key[at];
                for (i = at; i + 1 < list_count; i++) begin
                    list_handle[i] = list_handle[i+1];
                    list_key[i] = list_key[i+1];
                end
                list_count--;
            end
        end
        return r;
    endfunction

    task automatic queue_cmd(logic [CMD_WIDTH-1:0] op, t_handle h, t_key k);
        t_cmd_item c;
        c.op = op;
        c.handle = h;
        c.key = k;
        c.drain = 1'b0;
        pending_cmds.push_back(c);
    endtask

    task automatic queue_drain();
        t_cmd_item c;
        c.op = CMD_NOP;
        c.handle = '0;
        c.key = '0;
        c.drain = 1'b1;
        pending_cmds.push_back(c);
    endtask

    task automatic report(string field, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            error_count++;
            $display("%0t: %s mismatch, expected %h actual %h", $time, field, want, got);
        end
    endtask

    // driver: advance to the next item only once the current one is taken
    always @(negedge i_clk) begin
        t_cmd_item c;
        logic nxt_valid;
        logic [S_DATA_WIDTH-1:0] nxt_data;
        if (i_rst_n && (!s_axis_tvalid || in_fire)) begin
            nxt_valid = 1'b0;
            nxt_data = s_axis_tdata;
            if (drain_wait && expected_results.size() == 0) drain_wait = 1'b0;
            if (!drain_wait && pending_cmds.size() > 0) begin
                if (pending_cmds[0].drain) begin
                    drain_wait = 1'b1;
                    void'(pending_cmds.pop_front());
                end else if (no_idle || $urandom_range(0, 99) >= 15) begin
                    c = pending_cmds.pop_front();
                    nxt_valid = 1'b1;
                    nxt_data = {2'b00, c.key, c.handle, c.op};
                end
            end
            s_axis_tvalid <= nxt_valid;
            s_axis_tdata <= nxt_data;
        end
    end

    // receiver: random backpressure plus one long hold-off
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else if (!hold_done && cmds_accepted >= 400) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= no_idle || ($urandom_range(0, 99) >= 15);
        end
    end

    // monitor: check results first, then predict for the item taken at this edge
    always @(posedge i_clk) begin
        t_list_result want;
        in_fire = 1'b0;
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_results.size() == 0) begin
                    error_count++;
                    $display("%0t: unexpected result, expected none actual %h",
                             $time, m_axis_tdata);
                end else begin
                    want = expected_results.pop_front();
                    report("out_handle", 32'(want.handle), 32'(m_axis_tdata[3:0]));
                    report("out_valid", 32'(want.valid), 32'(m_axis_tdata[4]));
                    report("out_key", want.key, m_axis_tdata[36:5]);
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                in_fire = 1'b1;
                cmds_accepted++;
                expected_results.push_back(list_apply(s_axis_tdata[1:0], s_axis_tdata[5:2],
                                                      s_axis_tdata[37:6]));
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin
        int n;
        int h;
        int r;
        int ins_pct;
        t_key k;

        // empty list corner cases
        queue_cmd(CMD_POP, 4'hF, 32'hFFFF_FFFF);
        queue_cmd(CMD_REMOVE, 4'hF, 32'h0);
        queue_cmd(CMD_NOP, 4'h0, 32'h0);
        // fill in descending key order with equal-key pairs
        for (h = 15; h >= 0; h--) begin
            k = ((h >> 1) == 7) ? 32'hFFFF_FFFF : t_key'(h >> 1) * 32'h2000_0000;
            queue_cmd(CMD_INSERT, t_handle'(h), k);
        end
        queue_cmd(CMD_INSERT, 4'h3, 32'h1);
        queue_cmd(CMD_REMOVE, 4'h8, 32'h0);
        queue_cmd(CMD_REMOVE, 4'h8, 32'h0);
        queue_cmd(CMD_POP, 4'h0, 32'h0);
        queue_cmd(CMD_INSERT, 4'h1, 32'h0);
        queue_cmd(CMD_INSERT, 4'h0, 32'hFFFF_FFFF);
        queue_cmd(CMD_NOP, 4'hF, 32'hFFFF_FFFF);
        queue_drain();

        for (n = 0; n < RANDOM_CMDS; n++) begin
            if (n == 900) queue_drain();
            ins_pct = ((n / 80) % 2 == 0) ? 65 : 30;
            r = $urandom_range(0, 99);
            case ($urandom_range(0, 9))
                0, 1, 2, 3: k = $urandom_range(0, 7);
                4:          k = 32'h0;
                5:          k = 32'hFFFF_FFFF;
                default:    k = $urandom;
            endcase
            h = $urandom_range(0, 15);
            if (r < 3)
                queue_cmd(CMD_NOP, t_handle'(h), k);
            else if (r < ins_pct)
                queue_cmd(CMD_INSERT, t_handle'(h), k);
            else if ($urandom_range(0, 1) == 0)
                queue_cmd(CMD_POP, t_handle'(h), k);
            else
                queue_cmd(CMD_REMOVE, t_handle'(h), k);
        end

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_cmds.size() > 0 || s_axis_tvalid || drain_wait
               || expected_results.size() > 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
